// ===== src/packed_binary_dilation_3x3_macros.svh =====
// Assertion shorthands for the dilation block. Each one samples on the
// rising edge of clk and is switched off while rst_n is low.
`ifndef PACKED_BINARY_DILATION_3X3_MACROS_SVH
`define PACKED_BINARY_DILATION_3X3_MACROS_SVH

// The condition must never hold.
`define PBD_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Whenever ante holds, cons holds in the same cycle.
`define PBD_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever ante holds, cons holds in the following cycle.
`define PBD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pbd_pkg.sv =====
package pbd_pkg;

    localparam int MAX_WIDTH_BYTES_DEF = 256;
    localparam int MAX_ROWS_DEF        = 4096;

    localparam int BYTE_W       = 8;
    localparam int WIDTH_REG_W  = 9;
    localparam int HEIGHT_REG_W = 13;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd1;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1;

    // One pending column completion: horizontal result plus its tags.
    typedef struct packed {
        logic [BYTE_W-1:0] h;
        logic              row_end;
        logic              pad_row;
        logic              emit;
    } job_t;

    // One line buffer entry: the horizontal results of the two rows above.
    typedef struct packed {
        logic [BYTE_W-1:0] upper;
        logic [BYTE_W-1:0] middle;
    } line_t;

    function automatic logic [BYTE_W-1:0] hdilate(
        input logic [BYTE_W-1:0] x,
        input logic              lbit,
        input logic              rbit
    );
        hdilate = x | {x[BYTE_W-2:0], 1'b0} | {1'b0, x[BYTE_W-1:1]}
                | {{(BYTE_W-1){1'b0}}, rbit} | {lbit, {(BYTE_W-1){1'b0}}};
    endfunction

endpackage

// ===== src/pbd_cfg.sv =====
module pbd_cfg
    import pbd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [WIDTH_REG_W-1:0]  width_bytes,
    output logic [HEIGHT_REG_W-1:0] height_rows
);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    wr;
    logic                    idx;

    assign wr          = psel && penable && pwrite;
    assign idx         = paddr[APB_ADDR_W-1];
    assign pready      = 1'b1;
    assign width_bytes = width_reg;
    assign height_rows = height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_IDX_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-2:0] == '0)
        begin
            unique case (idx)
                REG_IDX_WIDTH:  prdata = APB_DATA_W'(width_reg);
                REG_IDX_HEIGHT: prdata = APB_DATA_W'(height_reg);
            endcase
        end
    end

endmodule

// ===== src/pbd_front.sv =====
module pbd_front
    import pbd_pkg::*;
#(
    parameter int MAX_WIDTH_BYTES = MAX_WIDTH_BYTES_DEF,
    parameter int MAX_ROWS        = MAX_ROWS_DEF,
    localparam int CW             = $clog2(MAX_WIDTH_BYTES)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [BYTE_W-1:0]       pixel_byte,
    input  logic                    is_padding,
    input  logic [WIDTH_REG_W-1:0]  width_bytes,
    input  logic [HEIGHT_REG_W-1:0] height_rows,
    output logic                    a_valid,
    output logic [CW-1:0]           a_col,
    output job_t                    a_job,
    output logic                    b_valid,
    output logic [CW-1:0]           b_col,
    output job_t                    b_job,
    output logic [1:0]              n_new
);

    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int WCMP = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
    localparam int HCMP = (RW > HEIGHT_REG_W) ? RW : HEIGHT_REG_W;

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    logic              left_reg, left_next;

    logic [WCMP-1:0]   width_ext;
    logic [WCMP-1:0]   wlast;
    logic [HCMP-1:0]   height_ext;
    logic [HCMP-1:0]   hgt;
    logic              last;
    logic              pad_row;
    logic              emit;
    logic              lbit;
    logic [BYTE_W-1:0] x;

    always_comb
    begin
        width_ext  = WCMP'(width_bytes);
        height_ext = HCMP'(height_rows);

        priority if (width_ext == '0)
            wlast = '0;
        else if (width_ext > WCMP'(MAX_WIDTH_BYTES))
            wlast = WCMP'(MAX_WIDTH_BYTES - 1);
        else
            wlast = width_ext - WCMP'(1);

        priority if (height_ext == '0)
            hgt = HCMP'(1);
        else if (height_ext > HCMP'(MAX_ROWS))
            hgt = HCMP'(MAX_ROWS);
        else
            hgt = height_ext;

        last    = WCMP'(col_reg) >= wlast;
        pad_row = HCMP'(row_reg) >= hgt;
        emit    = row_reg != '0;
        x       = (is_padding || pad_row) ? '0 : pixel_byte;

        // The held byte is completed once its right neighbor is known.
        a_valid = col_reg != '0;
        lbit    = a_valid ? held_reg[0] : 1'b0;
        a_col   = col_reg - CW'(1);
        a_job   = '{h: hdilate(held_reg, left_reg, x[BYTE_W-1]), row_end: 1'b0,
                    pad_row: pad_row, emit: emit};

        b_valid = last;
        b_col   = col_reg;
        b_job   = '{h: hdilate(x, lbit, 1'b0), row_end: 1'b1,
                    pad_row: pad_row, emit: emit};

        n_new   = {1'b0, a_valid} + {1'b0, b_valid};

        if (last)
        begin
            col_next  = '0;
            left_next = 1'b0;
            held_next = '0;
            row_next  = pad_row ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next  = col_reg + CW'(1);
            left_next = lbit;
            held_next = x;
            row_next  = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
            left_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
            left_reg <= left_next;
        end
    end

endmodule

// ===== src/pbd_jobq.sv =====
module pbd_jobq
    import pbd_pkg::*;
#(
    parameter int CW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_a,
    input  logic [CW-1:0] a_col,
    input  job_t          a_job,
    input  logic          push_b,
    input  logic [CW-1:0] b_col,
    input  job_t          b_job,
    input  logic          pop,
    output logic [CW-1:0] head_col,
    output job_t          head_job,
    output logic [1:0]    count
);

    logic [1:0]    count_reg, count_next;
    logic [CW-1:0] col0_reg, col0_next, col1_reg, col1_next;
    job_t          job0_reg, job0_next, job1_reg, job1_next;
    logic [1:0]    kept;

    assign head_col = col0_reg;
    assign head_job = job0_reg;
    assign count    = count_reg;

    always_comb
    begin
        kept      = count_reg - {1'b0, pop};
        col0_next = col0_reg;
        job0_next = job0_reg;
        col1_next = col1_reg;
        job1_next = job1_reg;

        unique case (kept)
            2'd0:
            begin
                if (push_a)
                begin
                    col0_next = a_col;
                    job0_next = a_job;
                    col1_next = b_col;
                    job1_next = b_job;
                end
                else
                begin
                    col0_next = b_col;
                    job0_next = b_job;
                end
            end
            2'd1:
            begin
                if (pop)
                begin
                    col0_next = col1_reg;
                    job0_next = job1_reg;
                end
                col1_next = push_a ? a_col : b_col;
                job1_next = push_a ? a_job : b_job;
            end
            default:
            begin
                col0_next = col0_reg;
            end
        endcase

        count_next = kept + {1'b0, push_a} + {1'b0, push_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        col0_reg <= col0_next;
        job0_reg <= job0_next;
        col1_reg <= col1_next;
        job1_reg <= job1_next;
    end

endmodule

// ===== src/pbd_line_mem.sv =====
module pbd_line_mem
    import pbd_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_BYTES_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output line_t         rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  line_t         wr_data,
    output logic          busy
);

    line_t         line_mem [DEPTH];
    line_t         rd_data_reg;
    logic          busy_reg;
    logic [AW-1:0] clr_reg;
    logic          we;
    logic [AW-1:0] wa;
    line_t         wd;

    assign busy    = busy_reg;
    assign rd_data = rd_data_reg;
    assign we      = busy_reg || wr_en;
    assign wa      = busy_reg ? clr_reg : wr_addr;
    assign wd      = busy_reg ? '0 : wr_data;

    // After reset every entry is written with zero, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_reg == AW'(DEPTH - 1))
                busy_reg <= 1'b0;
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // A read of the entry being written in the same cycle returns the new value.
    always_ff @(posedge clk)
    begin
        if (we)
            line_mem[wa] <= wd;
        if (rd_en)
            rd_data_reg <= (we && (wa == rd_addr)) ? wd : line_mem[rd_addr];
    end

endmodule

// ===== src/pbd_back.sv =====
module pbd_back
    import pbd_pkg::*;
#(
    parameter int CW = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_nonempty,
    input  logic [CW-1:0]     head_col,
    input  job_t              head_job,
    output logic              pop,
    input  line_t             rd_data,
    output logic              wr_en,
    output logic [CW-1:0]     wr_addr,
    output line_t             wr_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] dilated_byte,
    output logic              row_last,
    output logic              frame_last
);

    logic              e_valid_reg, e_valid_next;
    logic [CW-1:0]     e_col_reg;
    job_t              e_job_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_row_last_reg;
    logic              out_frame_last_reg;

    logic              out_free;
    logic              e_fire;
    logic              advance;
    logic [BYTE_W-1:0] result;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        e_fire   = e_valid_reg && (!e_job_reg.emit || out_free);
        advance  = !e_valid_reg || e_fire;
        pop      = advance && q_nonempty;

        result   = rd_data.upper | rd_data.middle | e_job_reg.h;

        wr_en    = e_fire;
        wr_addr  = e_col_reg;
        if (e_job_reg.pad_row)
            wr_data = '0;
        else
            wr_data = '{upper: rd_data.middle, middle: e_job_reg.h};

        if (pop)
            e_valid_next = 1'b1;
        else if (e_fire)
            e_valid_next = 1'b0;
        else
            e_valid_next = e_valid_reg;

        if (e_fire && e_job_reg.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg   <= e_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_col_reg <= head_col;
            e_job_reg <= head_job;
        end
        if (e_fire && e_job_reg.emit)
        begin
            out_byte_reg       <= result;
            out_row_last_reg   <= e_job_reg.row_end;
            out_frame_last_reg <= e_job_reg.row_end && e_job_reg.pad_row;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dilated_byte = out_byte_reg;
    assign row_last     = out_row_last_reg;
    assign frame_last   = out_frame_last_reg;

endmodule

// ===== src/packed_binary_dilation_3x3.sv =====
// 3x3 binary dilation of a bit-packed image. Bytes of eight pixels (leftmost
// pixel in the MSB) arrive in raster order, and each frame ends with one
// padding row of width_bytes bytes; output row r comes out while input row
// r+1 streams in, one byte behind, so the first input row gives no beats and
// the last byte of every later row gives two when the row has more than one
// byte. The block takes one input beat per clock while in_stall is low and
// sends at most one result beat per clock; with the output free it sustains
// one input beat every cycle at any width, because each input row yields
// exactly width_bytes column updates and the line buffer does one read and
// one write per update. Updates pass through the job queue, the execute
// register and the output register. After reset the line buffer is cleared
// entry by entry with in_stall high, and register writes are taken as usual.
// Registers must be written only while the block is idle; it does not check.
`include "packed_binary_dilation_3x3_macros.svh"

module packed_binary_dilation_3x3
    import pbd_pkg::*;
#(
    parameter int MAX_WIDTH_BYTES = MAX_WIDTH_BYTES_DEF,
    parameter int MAX_ROWS        = MAX_ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     pixel_byte,
    input  logic                  is_padding,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     dilated_byte,
    output logic                  row_last,
    output logic                  frame_last
);

    localparam int CW = $clog2(MAX_WIDTH_BYTES);

    logic [WIDTH_REG_W-1:0]  width_bytes;
    logic [HEIGHT_REG_W-1:0] height_rows;

    logic          accept;
    logic          a_valid, b_valid;
    logic [CW-1:0] a_col, b_col;
    job_t          a_job, b_job;
    logic [1:0]    n_new;

    logic [CW-1:0] head_col;
    job_t          head_job;
    logic [1:0]    q_count;
    logic          pop;

    line_t         rd_data;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    line_t         wr_data;
    logic          clr_busy;

    logic [2:0]    q_load;

    assign q_load   = {1'b0, q_count} - {2'b0, pop} + {1'b0, n_new};
    assign in_stall = clr_busy || (q_load > 3'd2);
    assign accept   = in_valid && !in_stall;

    pbd_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .width_bytes (width_bytes),
        .height_rows (height_rows)
    );

    pbd_front #(
        .MAX_WIDTH_BYTES (MAX_WIDTH_BYTES),
        .MAX_ROWS        (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel_byte  (pixel_byte),
        .is_padding  (is_padding),
        .width_bytes (width_bytes),
        .height_rows (height_rows),
        .a_valid     (a_valid),
        .a_col       (a_col),
        .a_job       (a_job),
        .b_valid     (b_valid),
        .b_col       (b_col),
        .b_job       (b_job),
        .n_new       (n_new)
    );

    pbd_jobq #(
        .CW (CW)
    ) u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_a   (accept && a_valid),
        .a_col    (a_col),
        .a_job    (a_job),
        .push_b   (accept && b_valid),
        .b_col    (b_col),
        .b_job    (b_job),
        .pop      (pop),
        .head_col (head_col),
        .head_job (head_job),
        .count    (q_count)
    );

    pbd_line_mem #(
        .DEPTH (MAX_WIDTH_BYTES)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pop),
        .rd_addr (head_col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (clr_busy)
    );

    pbd_back #(
        .CW (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_nonempty   (q_count != 2'd0),
        .head_col     (head_col),
        .head_job     (head_job),
        .pop          (pop),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dilated_byte (dilated_byte),
        .row_last     (row_last),
        .frame_last   (frame_last)
    );

    `PBD_ASSERT_NEVER(a_queue_bound, q_count == 2'd3, "job queue holds more than two entries")
    `PBD_ASSERT_NEXT(a_row_end_fill, accept && n_new == 2'd2, q_count == 2'd2, "queue not full")
    `PBD_ASSERT_IMPLY(a_frame_end_row_end, out_valid && frame_last, row_last, "frame_last alone")
    `PBD_ASSERT_IMPLY(a_clear_quiet, clr_busy, q_count == 2'd0 && !out_valid, "busy during clear")

endmodule

// ===== sim/tb_packed_binary_dilation_3x3.sv =====
module tb_packed_binary_dilation_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import pbd_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] dilated;
        logic              row_end;
        logic              frame_end;
    } dil_beat_t;

    typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_DENSE, FILL_ZERO} fill_e;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     pixel_byte;
    logic                  is_padding;
    logic                  out_valid;
    logic                  out_stall;
    logic [BYTE_W-1:0]     dilated_byte;
    logic                  row_last;
    logic                  frame_last;

    // Software copy of the block: line buffers, held byte and counters.
    logic [BYTE_W-1:0]       row_above_h [MAX_WIDTH_BYTES_DEF];
    logic [BYTE_W-1:0]       row_prev_h [MAX_WIDTH_BYTES_DEF];
    logic [BYTE_W-1:0]       held_px;
    logic                    held_lbit;
    int                      col_pos;
    int                      row_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    dil_beat_t pending_dilated[$];

    int idle_pct;
    int stall_pct;
    bit hold_request;
    int hold_cycles_req;
    int items_sent;
    int results_checked;
    int frames_sent;
    int error_count;

    packed_binary_dilation_3x3 i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_byte   (pixel_byte),
        .is_padding   (is_padding),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dilated_byte (dilated_byte),
        .row_last     (row_last),
        .frame_last   (frame_last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL packed_binary_dilation_3x3");
        $finish;
    end

    function automatic int width_eff();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH_BYTES_DEF)
            return MAX_WIDTH_BYTES_DEF;
        return int'(width_reg);
    endfunction

    function automatic int height_eff();
        if (height_reg == 0)
            return 1;
        if (height_reg > MAX_ROWS_DEF)
            return MAX_ROWS_DEF;
        return int'(height_reg);
    endfunction

    task automatic clear_dilation_model();
        for (int i = 0; i < MAX_WIDTH_BYTES_DEF; i++)
        begin
            row_above_h[i] = '0;
            row_prev_h[i] = '0;
        end
        held_px = '0;
        held_lbit = 1'b0;
        col_pos = 0;
        row_pos = 0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
    endtask

    // Finishes one column: horizontal OR with both neighbor bits, then the
    // vertical OR with the two buffered rows.
    task automatic close_column(input logic [BYTE_W-1:0] x, input logic lbit,
                                input logic rbit, input int col,
                                input bit row_end, input bit pad_row);
        logic [BYTE_W-1:0] h;
        dil_beat_t beat;
        h = x | (x << 1) | (x >> 1) | {7'b0, rbit} | {lbit, 7'b0};
        if (row_pos >= 1)
        begin
            beat.dilated = row_above_h[col] | row_prev_h[col] | h;
            beat.row_end = row_end;
            beat.frame_end = row_end && pad_row;
            pending_dilated.push_back(beat);
        end
        if (pad_row)
        begin
            row_above_h[col] = '0;
            row_prev_h[col] = '0;
        end
        else
        begin
            row_above_h[col] = row_prev_h[col];
            row_prev_h[col] = h;
        end
    endtask

    task automatic predict_dilation(input logic [BYTE_W-1:0] px, input logic pad);
        int w;
        int c;
        bit pad_row;
        bit last;
        logic [BYTE_W-1:0] x;
        logic lbit;
        w = width_eff();
        pad_row = row_pos >= height_eff();
        x = (pad || pad_row) ? '0 : px;
        c = col_pos;
        last = (c + 1) >= w;
        lbit = 1'b0;
        if (c > 0)
        begin
            close_column(held_px, held_lbit, x[BYTE_W-1], c - 1, 1'b0, pad_row);
            lbit = held_px[0];
        end
        if (last)
        begin
            close_column(x, lbit, 1'b0, c, 1'b1, pad_row);
            col_pos = 0;
            held_lbit = 1'b0;
            held_px = '0;
            row_pos = pad_row ? 0 : ((row_pos + 1) & 32'h1FFF);
        end
        else
        begin
            held_lbit = lbit;
            held_px = x;
            col_pos = c + 1;
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_pixels(input fill_e fill);
        case (fill)
            FILL_ZERO:   return 8'h00;
            FILL_DENSE:  return ($urandom_range(3) == 0) ? ~(8'h01 << $urandom_range(7)) : 8'hFF;
            FILL_SPARSE: return ($urandom_range(2) == 0) ? (8'h01 << $urandom_range(7)) : 8'h00;
            default:     return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] px, input logic pad);
        logic stalled;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_byte <= px;
        is_padding <= pad;
        forever
        begin
            @(negedge clk);
            stalled = (in_stall !== 1'b0);
            @(posedge clk);
            if (!stalled)
                break;
        end
        predict_dilation(px, pad);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_dilated.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_IDX_WIDTH)
            width_reg = value[WIDTH_REG_W-1:0];
        else
            height_reg = value[HEIGHT_REG_W-1:0];
    endtask

    task automatic configure(input int w, input int h);
        wait_idle();
        apb_write(REG_IDX_WIDTH, w);
        apb_write(REG_IDX_HEIGHT, h);
    endtask

    // The padding row mostly carries the flag, but the row index alone decides.
    task automatic send_frame(input fill_e fill);
        int w;
        int h;
        w = width_eff();
        h = height_eff();
        for (int r = 0; r <= h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                if (r == h)
                    send_beat(pick_pixels(fill), $urandom_range(7) != 0);
                else
                    send_beat(pick_pixels(fill), $urandom_range(19) == 0);
            end
        end
        frames_sent++;
    endtask

    task automatic set_idling(input int sender, input int receiver);
        idle_pct = sender;
        stall_pct = receiver;
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        configure(1, 1);
        send_beat(8'hA5, 1'b0);
        send_beat(8'h3C, 1'b1);
        frames_sent++;

        // Zero in either register acts as one.
        configure(0, 0);
        send_beat(8'h81, 1'b0);
        send_beat(8'hFF, 1'b0);
        frames_sent++;

        configure(3, 2);
        send_beat(8'h80, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h7E, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
        frames_sent++;

        // Registers changed in the middle of a frame while the block is idle.
        configure(4, 3);
        send_beat(8'h18, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hC3, 1'b0);
        send_beat(8'h10, 1'b0);
        send_beat(8'h08, 1'b0);
        wait_idle();
        apb_write(REG_IDX_WIDTH, 2);
        send_beat(8'h55, 1'b0);
        wait_idle();
        apb_write(REG_IDX_HEIGHT, 1);
        send_beat(8'hAA, 1'b1);
        send_beat(8'h0F, 1'b1);
        frames_sent++;
        wait_idle();
    endtask

    task automatic test_random_frames(input int sender, input int receiver, input int goal);
        int start;
        int pick;
        int w;
        int h;
        set_idling(sender, receiver);
        start = items_sent;
        while (items_sent - start < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                w = $urandom_range(8, 1);
            else if (pick < 95)
                w = $urandom_range(40, 9);
            else
                w = $urandom_range(64, 41);
            if ($urandom_range(15) == 0)
                w = 0;
            h = ($urandom_range(7) == 0) ? $urandom_range(12, 0) : $urandom_range(6, 1);
            configure(w, h);
            send_frame(fill_e'($urandom_range(3)));
        end
        wait_idle();
    endtask

    // An oversized width acts as the full line buffer width.
    task automatic test_width_extremes();
        set_idling(0, 0);
        configure(511, 1);
        send_frame(FILL_RANDOM);
        wait_idle();
    endtask

    // A tall frame under an oversized height, ended by lowering the height.
    task automatic test_height_extremes();
        set_idling(0, 0);
        configure(1, 8191);
        for (int r = 0; r < 30; r++)
            send_beat(pick_pixels(FILL_RANDOM), 1'b0);
        wait_idle();
        apb_write(REG_IDX_HEIGHT, 0);
        send_beat(8'hFF, 1'b1);
        frames_sent++;
        wait_idle();
    endtask

    task automatic test_output_hold_off();
        set_idling(0, 0);
        configure(24, 3);
        hold_cycles_req = 400;
        hold_request = 1'b1;
        send_frame(FILL_RANDOM);
        wait_idle();
    endtask

    // Receiver side: random stalls, or one long hold-off when requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = hold_cycles_req;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        logic seen;
        dil_beat_t got;
        dil_beat_t want;
        forever
        begin
            @(negedge clk);
            seen = (rst_n === 1'b1) && (out_valid === 1'b1) && (out_stall === 1'b0);
            got = {dilated_byte, row_last, frame_last};
            @(posedge clk);
            if (seen)
            begin
                results_checked++;
                if (pending_dilated.size() == 0)
                begin
                    $error("unexpected result beat: dilated_byte %02h", got.dilated);
                    error_count++;
                end
                else
                begin
                    want = pending_dilated.pop_front();
                    if (got.dilated !== want.dilated)
                    begin
                        $error("dilated_byte: expected %02h, got %02h",
                               want.dilated, got.dilated);
                        error_count++;
                    end
                    if (got.row_end !== want.row_end)
                    begin
                        $error("row_last: expected %0b, got %0b", want.row_end, got.row_end);
                        error_count++;
                    end
                    if (got.frame_end !== want.frame_end)
                    begin
                        $error("frame_last: expected %0b, got %0b",
                               want.frame_end, got.frame_end);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        idle_pct = 0;
        stall_pct = 0;
        hold_request = 1'b0;
        hold_cycles_req = 0;
        items_sent = 0;
        results_checked = 0;
        frames_sent = 0;
        error_count = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        pixel_byte <= '0;
        is_padding <= 1'b0;
        clear_dilation_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_frames(0, 0, 120);
        test_random_frames(81, 0, 120);
        test_random_frames(0, 81, 120);
        test_random_frames(23, 23, 120);
        test_width_extremes();
        test_height_extremes();
        test_output_hold_off();
        wait_idle();

        $display("Covered %0d frames: %0d input beats, %0d result beats checked.",
                 frames_sent, items_sent, results_checked);
        $display("Widths up to the full line buffer, zero and oversized registers, "
                 , "a tall frame cut short, random idling and stalls, one long hold-off.");
        if (error_count == 0 && pending_dilated.size() == 0)
            $display("PASS packed_binary_dilation_3x3");
        else
            $display("FAIL packed_binary_dilation_3x3");
        $finish;
    end

endmodule
